@@ src/wlw_pkg.sv @@
// Shared types, constants and lookup functions of the wall-loss line walk.
`default_nettype none

package wlw_pkg;

    // Result, accumulator and field widths; result and accumulator are 25 bits wide.
    localparam int OUT_W   = 25;
    localparam int ACC_W   = 25;
    localparam int MAT_W   = 3;
    localparam int LOSS_W  = 12;
    localparam int PT_W    = 15;
    localparam int QUO_W   = 20;
    localparam int REM_W   = 5;
    localparam int FRAC_W  = 5;
    localparam int RECIP_W = 28;
    localparam int RECIP_SHIFT = 32;

    // Sums in 1/200 dB at or above this give a result beyond the output range.
    localparam logic [ACC_W-1:0] SAT_LIM = 25'd26214400;

    // Reciprocal of 25 scaled by 2^32, rounded up; exact for sums below 2^25.
    localparam logic [RECIP_W-1:0] RECIP_25 = 28'd171798692;

    // Register indexes of the configuration port.
    localparam int REG_AP_X   = 0;
    localparam int REG_AP_Y   = 1;
    localparam int REG_WALL_0 = 2;

    // Material codes; anything else adds no loss.
    localparam logic [MAT_W-1:0] MAT_EMPTY    = 3'd0;
    localparam logic [MAT_W-1:0] MAT_GLASS    = 3'd1;
    localparam logic [MAT_W-1:0] MAT_COATED   = 3'd2;
    localparam logic [MAT_W-1:0] MAT_CONCRETE = 3'd3;
    localparam logic [MAT_W-1:0] MAT_WOOD     = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic visit;
        logic mul;
        logic quo;
        logic fin;
    } wlw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic at_end;
    } wlw_stat_t;

    // Loss of one wall crossing at 5 GHz, in units of 1/200 dB.
    function automatic logic [LOSS_W-1:0] mat_loss(input logic [MAT_W-1:0] mat);
        logic [LOSS_W-1:0] loss;
        unique case (mat)
            MAT_GLASS:    loss = 12'd420;
            MAT_COATED:   loss = 12'd3430;
            MAT_CONCRETE: loss = 12'd385;
            MAT_WOOD:     loss = 12'd763;
            default:      loss = '0;
        endcase
        return loss;
    endfunction

    // floor(32 * r / 25) for a remainder r below 25.
    function automatic logic [FRAC_W-1:0] frac_tab(input logic [REM_W-1:0] r);
        logic [FRAC_W-1:0] f;
        case (r)
            5'd0:    f = 5'd0;
            5'd1:    f = 5'd1;
            5'd2:    f = 5'd2;
            5'd3:    f = 5'd3;
            5'd4:    f = 5'd5;
            5'd5:    f = 5'd6;
            5'd6:    f = 5'd7;
            5'd7:    f = 5'd8;
            5'd8:    f = 5'd10;
            5'd9:    f = 5'd11;
            5'd10:   f = 5'd12;
            5'd11:   f = 5'd14;
            5'd12:   f = 5'd15;
            5'd13:   f = 5'd16;
            5'd14:   f = 5'd17;
            5'd15:   f = 5'd19;
            5'd16:   f = 5'd20;
            5'd17:   f = 5'd21;
            5'd18:   f = 5'd23;
            5'd19:   f = 5'd24;
            5'd20:   f = 5'd25;
            5'd21:   f = 5'd26;
            5'd22:   f = 5'd28;
            5'd23:   f = 5'd29;
            5'd24:   f = 5'd30;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

@@ src/wlw_cfg_regs.sv @@
// Configuration registers: access point position and wall slots.
`default_nettype none

module wlw_cfg_regs #(
    parameter int WALL_SLOTS = 4,
    parameter int COORD_BITS = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [$clog2(WALL_SLOTS+2)-1:0]       cfg_idx,
    input  logic [4*COORD_BITS+wlw_pkg::MAT_W-1:0] cfg_data,
    output logic [COORD_BITS-1:0]                 ap_x,
    output logic [COORD_BITS-1:0]                 ap_y,
    output logic [WALL_SLOTS-1:0][4*COORD_BITS+wlw_pkg::MAT_W-1:0] walls
);
    import wlw_pkg::*;

    localparam int IDX_W = $clog2(WALL_SLOTS + 2);

    logic [COORD_BITS-1:0] ap_x_reg;
    logic [COORD_BITS-1:0] ap_y_reg;
    logic [WALL_SLOTS-1:0][4*COORD_BITS+MAT_W-1:0] walls_reg;

    // Register writes; an index past the last wall slot is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ap_x_reg  <= '0;
            ap_y_reg  <= '0;
            walls_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_idx == IDX_W'(REG_AP_X))
            begin
                ap_x_reg <= cfg_data[COORD_BITS-1:0];
            end
            if (cfg_idx == IDX_W'(REG_AP_Y))
            begin
                ap_y_reg <= cfg_data[COORD_BITS-1:0];
            end
            for (int k = 0; k < WALL_SLOTS; k++)
            begin
                if (cfg_idx == IDX_W'(REG_WALL_0 + k))
                begin
                    walls_reg[k] <= cfg_data;
                end
            end
        end
    end

    assign ap_x  = ap_x_reg;
    assign ap_y  = ap_y_reg;
    assign walls = walls_reg;

endmodule

`default_nettype wire

@@ src/wlw_ctrl.sv @@
// Controller state machine sequencing the line walk and the final scaling.
`default_nettype none

module wlw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output wlw_pkg::wlw_cmd_t cmd,
    input  wlw_pkg::wlw_stat_t stat
);
    import wlw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_MUL,
        ST_QUO,
        ST_FIN
    } state_t;

    state_t state_reg;
    logic   done_reg;

    // State and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    if (stat.at_end)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: state_reg <= ST_MUL;
                ST_MUL:   state_reg <= ST_QUO;
                ST_QUO:   state_reg <= ST_FIN;
                ST_FIN:
                begin
                    state_reg <= ST_IDLE;
                    done_reg  <= 1'b1;
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    // Commands decoded from the state.
    always_comb
    begin
        cmd       = '0;
        cmd.load  = (state_reg == ST_IDLE) && start;
        cmd.visit = (state_reg == ST_WALK);
        cmd.mul   = (state_reg == ST_MUL);
        cmd.quo   = (state_reg == ST_QUO);
        cmd.fin   = (state_reg == ST_FIN);
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    // A result follows the final scaling step and never overlaps a walk.
    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_FIN))
        else $error("result strobe without a finished item");

    a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_WALK))
        else $error("accepted item did not start a walk");

    a_walk_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && !stat.at_end) |=> (state_reg == ST_WALK))
        else $error("walk left before reaching the access point");

endmodule

`default_nettype wire

@@ src/wlw_datapath.sv @@
// Datapath: Bresenham stepper, wall hit test, loss accumulator and Q17.8 scaling.
`default_nettype none

module wlw_datapath #(
    parameter int WALL_SLOTS = 4,
    parameter int COORD_BITS = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  wlw_pkg::wlw_cmd_t       cmd,
    output wlw_pkg::wlw_stat_t      stat,
    input  logic [COORD_BITS-1:0]   pixel_x,
    input  logic [COORD_BITS-1:0]   pixel_y,
    input  logic [COORD_BITS-1:0]   ap_x,
    input  logic [COORD_BITS-1:0]   ap_y,
    input  logic [WALL_SLOTS-1:0][4*COORD_BITS+wlw_pkg::MAT_W-1:0] walls,
    output logic [wlw_pkg::OUT_W-1:0] total_loss
);
    import wlw_pkg::*;

    localparam int ERR_W  = COORD_BITS + 2;
    localparam int E2_W   = COORD_BITS + 3;
    localparam int BND_W  = COORD_BITS + 1;
    localparam int PROD_W = ACC_W + RECIP_W;

    // Walk state.
    logic [COORD_BITS-1:0]   x_reg;
    logic [COORD_BITS-1:0]   y_reg;
    logic [COORD_BITS-1:0]   dx_reg;
    logic [COORD_BITS-1:0]   dy_reg;
    logic                    sx_neg_reg;
    logic                    sy_neg_reg;
    logic signed [ERR_W-1:0] err_reg;

    logic [COORD_BITS-1:0]   dx_ld;
    logic [COORD_BITS-1:0]   dy_ld;
    logic signed [E2_W-1:0]  e2;
    logic signed [E2_W-1:0]  dx_s;
    logic signed [E2_W-1:0]  dy_s;
    logic signed [E2_W-1:0]  err_ext;
    logic signed [E2_W-1:0]  err_sum;
    logic                    step_x;
    logic                    step_y;
    logic                    at_end;

    // Hit test and accumulation.
    logic [LOSS_W-1:0]       slot_loss_reg [WALL_SLOTS];
    logic                    loss_vld_reg;
    logic [PT_W-1:0]         pt_sum;
    logic [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]        acc_sum;

    // Scaling by 256/200.
    logic [PROD_W-1:0]       prod_reg;
    logic                    sat_reg;
    logic [QUO_W-1:0]        quo_reg;
    logic [ACC_W-1:0]        quo_x25;
    logic [REM_W-1:0]        rem;
    logic [OUT_W-1:0]        total_loss_reg;

    // Distances for a new walk.
    always_comb
    begin
        dx_ld = (ap_x > pixel_x) ? (ap_x - pixel_x) : (pixel_x - ap_x);
        dy_ld = (ap_y > pixel_y) ? (ap_y - pixel_y) : (pixel_y - ap_y);
    end

    // Error term decisions for one Bresenham step.
    always_comb
    begin
        dx_s    = {3'b000, dx_reg};
        dy_s    = {3'b000, dy_reg};
        err_ext = {err_reg[ERR_W-1], err_reg};
        e2      = {err_reg, 1'b0};
        step_x  = (e2 > -dy_s);
        step_y  = (e2 < dx_s);
        err_sum = err_ext;
        if (step_x)
        begin
            err_sum = err_sum - dy_s;
        end
        if (step_y)
        begin
            err_sum = err_sum + dx_s;
        end
    end

    assign at_end      = (x_reg == ap_x) && (y_reg == ap_y);
    assign stat.at_end = at_end;

    // Stepper: load on accept, advance one point per visited cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg      <= pixel_x;
            y_reg      <= pixel_y;
            dx_reg     <= dx_ld;
            dy_reg     <= dy_ld;
            sx_neg_reg <= !(pixel_x < ap_x);
            sy_neg_reg <= !(pixel_y < ap_y);
            err_reg    <= {2'b00, dx_ld} - {2'b00, dy_ld};
        end
        else if (cmd.visit && !at_end)
        begin
            err_reg <= err_sum[ERR_W-1:0];
            if (step_x)
            begin
                x_reg <= sx_neg_reg ? (x_reg - COORD_BITS'(1)) : (x_reg + COORD_BITS'(1));
            end
            if (step_y)
            begin
                y_reg <= sy_neg_reg ? (y_reg - COORD_BITS'(1)) : (y_reg + COORD_BITS'(1));
            end
        end
    end

    // Per-slot hit test at the current point, inclusive bounds.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < WALL_SLOTS; k++)
        begin
            logic [BND_W-1:0] px;
            logic [BND_W-1:0] py;
            logic [BND_W-1:0] wx;
            logic [BND_W-1:0] wy;
            logic [BND_W-1:0] wx_hi;
            logic [BND_W-1:0] wy_hi;
            px    = {1'b0, x_reg};
            py    = {1'b0, y_reg};
            wx    = {1'b0, walls[k][COORD_BITS-1:0]};
            wy    = {1'b0, walls[k][2*COORD_BITS-1:COORD_BITS]};
            wx_hi = wx + {1'b0, walls[k][3*COORD_BITS-1:2*COORD_BITS]};
            wy_hi = wy + {1'b0, walls[k][4*COORD_BITS-1:3*COORD_BITS]};
            if (px >= wx && px <= wx_hi && py >= wy && py <= wy_hi)
            begin
                slot_loss_reg[k] <= mat_loss(walls[k][4*COORD_BITS+MAT_W-1:4*COORD_BITS]);
            end
            else
            begin
                slot_loss_reg[k] <= '0;
            end
        end
    end

    // Marks a cycle whose slot losses belong to a visited point.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loss_vld_reg <= 1'b0;
        end
        else
        begin
            loss_vld_reg <= cmd.visit;
        end
    end

    // Sum of the slot losses at one point.
    always_comb
    begin
        pt_sum = '0;
        for (int k = 0; k < WALL_SLOTS; k++)
        begin
            pt_sum = pt_sum + PT_W'(slot_loss_reg[k]);
        end
        acc_sum = acc_reg + ACC_W'(pt_sum);
    end

    // Saturating accumulator in 1/200 dB.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            acc_reg <= '0;
        end
        else if (loss_vld_reg)
        begin
            acc_reg <= (acc_sum >= SAT_LIM) ? SAT_LIM : acc_sum;
        end
    end

    // Quotient by 25 from the reciprocal product, then the remainder.
    always_comb
    begin
        quo_x25 = ACC_W'({quo_reg, 4'b0000}) + ACC_W'({quo_reg, 3'b000}) + ACC_W'(quo_reg);
        rem     = REM_W'(acc_reg - quo_x25);
    end

    // Scaling steps: multiply, take the quotient, form the Q17.8 result.
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(acc_reg) * PROD_W'(RECIP_25);
            sat_reg  <= (acc_reg >= SAT_LIM);
        end
        if (cmd.quo)
        begin
            quo_reg <= prod_reg[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
        end
        if (cmd.fin)
        begin
            if (sat_reg)
            begin
                total_loss_reg <= '1;
            end
            else
            begin
                total_loss_reg <= {quo_reg, {FRAC_W{1'b0}}} + OUT_W'(frac_tab(rem));
            end
        end
    end

    assign total_loss = total_loss_reg;

endmodule

`default_nettype wire

@@ src/wall_loss_line_walk_core.sv @@
// Top level of the wall-loss line walk: configuration, controller and datapath.
// Done rises after the walk, a drain state and the multiply, quotient and final scaling
// states; N = max(|dx|, |dy|) + 1 is the number of points (1 to 2^COORD_BITS).
// The stepper visits one point per cycle; busy stays high until the item is done, so a
// new item is not taken before the last is through; start is taken while done shows.
// Reset clears the controller and all configuration registers to zero; the receiver
// cannot stall, and total_loss holds each result until the next final scaling step.
`default_nettype none

module wall_loss_line_walk_core #(
    parameter int WALL_SLOTS = 4,
    parameter int COORD_BITS = 10
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    output logic                                   done,
    input  logic [COORD_BITS-1:0]                  pixel_x,
    input  logic [COORD_BITS-1:0]                  pixel_y,
    output logic [wlw_pkg::OUT_W-1:0]              total_loss,
    input  logic                                   cfg_wr_en,
    input  logic [$clog2(WALL_SLOTS+2)-1:0]        cfg_idx,
    input  logic [4*COORD_BITS+wlw_pkg::MAT_W-1:0] cfg_data
);
    import wlw_pkg::*;

    logic [COORD_BITS-1:0] ap_x;
    logic [COORD_BITS-1:0] ap_y;
    logic [WALL_SLOTS-1:0][4*COORD_BITS+MAT_W-1:0] walls;
    wlw_cmd_t  cmd;
    wlw_stat_t stat;

    // Configuration registers.
    wlw_cfg_regs #(
        .WALL_SLOTS (WALL_SLOTS),
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .ap_x      (ap_x),
        .ap_y      (ap_y),
        .walls     (walls)
    );

    // Sequencer.
    wlw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Walk, hit test and scaling.
    wlw_datapath #(
        .WALL_SLOTS (WALL_SLOTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .ap_x       (ap_x),
        .ap_y       (ap_y),
        .walls      (walls),
        .total_loss (total_loss)
    );

endmodule

`default_nettype wire

@@ tb/wall_loss_line_walk_core_tb.sv @@
// Self-checking testbench for the wall-loss line walk core: scoreboard, drivers and top.
`default_nettype none

module wall_loss_line_walk_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wlw_pkg::*;

    localparam int WALL_SLOTS  = 4;
    localparam int COORD_BITS  = 10;
    localparam int IDX_W       = $clog2(WALL_SLOTS + 2);
    localparam int WALL_W      = 4 * COORD_BITS + MAT_W;
    localparam int HIGH_W      = WALL_W - COORD_BITS;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int CLK_HALF    = 10;
    localparam int RESET_CYCLES = 11;
    localparam int PHASE_ITEMS = 70;
    localparam int RAND_PHASES = 8;
    localparam int TAIL_CYCLES = 40;
    // Longest honest wait is one full-length walk plus a long sender gap.
    localparam int WATCHDOG_LIMIT = 6000;

    // First index past the wall slots; writes there must be ignored.
    localparam int REG_PAST_END = REG_WALL_0 + WALL_SLOTS;

    // Material codes with no defined loss.
    localparam logic [MAT_W-1:0] MAT_RSVD_5 = 3'd5;
    localparam logic [MAT_W-1:0] MAT_RSVD_6 = 3'd6;
    localparam logic [MAT_W-1:0] MAT_RSVD_7 = 3'd7;

    // Scoreboard: mirrors the configuration and predicts the loss of every walk.
    class loss_scoreboard;
        localparam int SLOTS = 4;
        localparam int CB    = 10;
        localparam longint unsigned LOSS_MAX = (64'd1 << OUT_W) - 64'd1;

        logic [CB-1:0]         ap_x;
        logic [CB-1:0]         ap_y;
        logic [4*CB+MAT_W-1:0] walls [SLOTS];
        int unsigned           mat_units [8];
        logic [OUT_W-1:0]      expected_loss [$];
        int                    mismatches;
        int                    walks_noted;
        int                    results_checked;

        function new();
            ap_x = '0;
            ap_y = '0;
            for (int k = 0; k < SLOTS; k++)
            begin
                walls[k] = '0;
            end
            // Losses per crossing in units of 1/200 dB.
            for (int m = 0; m < 8; m++)
            begin
                mat_units[m] = 0;
            end
            mat_units[MAT_GLASS]    = 420;
            mat_units[MAT_COATED]   = 3430;
            mat_units[MAT_CONCRETE] = 385;
            mat_units[MAT_WOOD]     = 763;
            mismatches      = 0;
            walks_noted     = 0;
            results_checked = 0;
        endfunction

        // Mirror one register write; indexes past the wall slots change nothing.
        function void write_reg(int idx, logic [4*CB+MAT_W-1:0] data);
            if (idx == REG_AP_X)
                ap_x = data[CB-1:0];
            else if (idx == REG_AP_Y)
                ap_y = data[CB-1:0];
            else if (idx >= REG_WALL_0 && idx < REG_WALL_0 + SLOTS)
                walls[idx - REG_WALL_0] = data;
        endfunction

        // Summed loss of every wall rectangle that contains the point.
        function longint unsigned point_units(longint x, longint y);
            longint unsigned units;
            longint          wx;
            longint          wy;
            longint          ln;
            longint          wd;
            logic [MAT_W-1:0] mat;
            units = 0;
            for (int k = 0; k < SLOTS; k++)
            begin
                wx  = longint'(walls[k][CB-1:0]);
                wy  = longint'(walls[k][2*CB-1:CB]);
                ln  = longint'(walls[k][3*CB-1:2*CB]);
                wd  = longint'(walls[k][4*CB-1:3*CB]);
                mat = walls[k][4*CB +: MAT_W];
                if (x >= wx && x <= wx + ln && y >= wy && y <= wy + wd)
                    units += 64'(mat_units[mat]);
            end
            return units;
        endfunction

        // Bresenham walk from the pixel to the access point, both ends counted.
        function logic [OUT_W-1:0] walk_loss(logic [CB-1:0] px, logic [CB-1:0] py);
            longint          x;
            longint          y;
            longint          tx;
            longint          ty;
            longint          dx;
            longint          dy;
            longint          sx;
            longint          sy;
            longint          err;
            longint          e2;
            longint unsigned units;
            longint unsigned q;
            bit              at_ap;
            x  = longint'(px);
            y  = longint'(py);
            tx = longint'(ap_x);
            ty = longint'(ap_y);
            dx = (tx > x) ? tx - x : x - tx;
            dy = (ty > y) ? ty - y : y - ty;
            sx = (x < tx) ? 1 : -1;
            sy = (y < ty) ? 1 : -1;
            err   = dx - dy;
            units = 0;
            at_ap = 1'b0;
            while (!at_ap)
            begin
                units += point_units(x, y);
                if (x == tx && y == ty)
                    at_ap = 1'b1;
                else
                begin
                    e2 = 2 * err;
                    if (e2 > -dy)
                    begin
                        err -= dy;
                        x   += sx;
                    end
                    if (e2 < dx)
                    begin
                        err += dx;
                        y   += sy;
                    end
                end
            end
            // One conversion from 1/200 dB to Q17.8, truncating.
            q = (units * 256) / 200;
            if (q > LOSS_MAX)
                q = LOSS_MAX;
            return q[OUT_W-1:0];
        endfunction

        // Note an accepted pixel and queue the loss it must produce.
        function void note_walk(logic [CB-1:0] px, logic [CB-1:0] py);
            expected_loss.push_back(walk_loss(px, py));
            walks_noted++;
        endfunction

        task report(string msg);
            mismatches++;
            $display("%0t ns  loss check failed: %s", $time, msg);
        endtask

        // Compare one result transfer with the oldest queued loss.
        task check_loss(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (expected_loss.size() == 0)
                report($sformatf("result 0x%0h with no walk outstanding", got));
            else
            begin
                want = expected_loss.pop_front();
                results_checked++;
                if (got !== want)
                    report($sformatf("walk %0d total_loss 0x%0h, want 0x%0h",
                                     results_checked, got, want));
            end
        endtask

        task close_out();
            if (expected_loss.size() != 0)
                report($sformatf("%0d walks never produced a result", expected_loss.size()));
        endtask
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   start     = 1'b0;
    logic                   busy;
    logic                   done;
    logic [COORD_BITS-1:0]  pixel_x   = '0;
    logic [COORD_BITS-1:0]  pixel_y   = '0;
    logic [OUT_W-1:0]       total_loss;
    logic                   cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]       cfg_idx   = '0;
    logic [WALL_W-1:0]      cfg_data  = '0;

    loss_scoreboard sb = new();
    int             idle_cycles = 0;
    int             settings_seen = 0;

    wall_loss_line_walk_core #(
        .WALL_SLOTS (WALL_SLOTS),
        .COORD_BITS (COORD_BITS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .done       (done),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .total_loss (total_loss),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data)
    );

    // Free-running clock.
    always #(CLK_HALF) clk = ~clk;

    // Every done strobe is a result transfer that must be taken in its cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_loss(total_loss);
    end

    // Watchdog: too long without any transfer means the block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles without a transfer.", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 150);
    endfunction

    function automatic int near_coord(int c, int span);
        int v;
        v = c + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v;
    endfunction

    function automatic logic [WALL_W-1:0] pack_wall(int x,
                                                    int y,
                                                    int ln,
                                                    int wd,
                                                    logic [MAT_W-1:0] mat);
        return {mat, COORD_BITS'(wd), COORD_BITS'(ln), COORD_BITS'(y), COORD_BITS'(x)};
    endfunction

    // One of the four materials with a defined loss.
    function automatic logic [MAT_W-1:0] pick_material();
        return MAT_W'($urandom_range(MAT_GLASS, MAT_WOOD));
    endfunction

    // Random wall: mostly a box or a thin strip near the access point.
    function automatic logic [WALL_W-1:0] rand_wall(int cx, int cy);
        int               r;
        int               m;
        logic [MAT_W-1:0] mat;
        r = $urandom_range(0, 99);
        m = $urandom_range(0, 99);
        if (m < 70)
            mat = pick_material();
        else if (m < 85)
            mat = MAT_EMPTY;
        else
            mat = MAT_W'($urandom_range(MAT_RSVD_5, MAT_RSVD_7));
        if (r < 55)
            return pack_wall(near_coord(cx - 20, 60), near_coord(cy - 20, 60),
                             $urandom_range(0, 60), $urandom_range(0, 60), mat);
        else if (r < 65)
            return pack_wall(near_coord(cx, 60), 0, 0, COORD_MAX, mat);
        else if (r < 75)
            return pack_wall(0, near_coord(cy, 60), COORD_MAX, 0, mat);
        else
            return WALL_W'({$urandom(), $urandom()});
    endfunction

    // Register write, landing at the next rising edge.
    task automatic write_cfg(int idx, logic [WALL_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= IDX_W'(idx);
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    // Offer one pixel and hold it until the block takes the transfer.
    task automatic send_pixel(int px, int py, int gap);
        start   <= 1'b1;
        pixel_x <= COORD_BITS'(px);
        pixel_y <= COORD_BITS'(py);
        do
            @(posedge clk);
        while (busy);
        sb.note_walk(COORD_BITS'(px), COORD_BITS'(py));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering work and wait until every queued result has come back.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_loss.size() != 0 || busy);
    endtask

    // New random setting of all registers, sometimes with the access point at a corner.
    task automatic randomize_config();
        int ax;
        int ay;
        if ($urandom_range(0, 99) < 20)
        begin
            ax = $urandom_range(0, 1) ? COORD_MAX : 0;
            ay = $urandom_range(0, 1) ? COORD_MAX : 0;
        end
        else
        begin
            ax = $urandom_range(0, COORD_MAX);
            ay = $urandom_range(0, COORD_MAX);
        end
        write_cfg(REG_AP_X, {HIGH_W'({$urandom(), $urandom()}), COORD_BITS'(ax)});
        write_cfg(REG_AP_Y, {HIGH_W'({$urandom(), $urandom()}), COORD_BITS'(ay)});
        for (int k = 0; k < WALL_SLOTS; k++)
        begin
            write_cfg(REG_WALL_0 + k, rand_wall(ax, ay));
        end
        if ($urandom_range(0, 99) < 30)
            write_cfg($urandom_range(REG_PAST_END, REG_PAST_END + 1),
                      WALL_W'({$urandom(), $urandom()}));
        cfg_wr_en <= 1'b0;
        settings_seen++;
    endtask

    initial
    begin
        int px;
        int py;
        int r;
        bit quiet;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: every slot empty, access point at the origin.
        settings_seen = 1;
        send_pixel(0, 0, pick_gap());
        send_pixel(COORD_MAX, COORD_MAX, pick_gap());
        drain();

        // One wall of each material; high data bits on the access point must be dropped.
        write_cfg(REG_AP_X, {{HIGH_W{1'b1}}, COORD_BITS'(300)});
        write_cfg(REG_AP_Y, {{HIGH_W{1'b1}}, COORD_BITS'(200)});
        write_cfg(REG_PAST_END, '1);
        write_cfg(REG_PAST_END + 1, '1);
        write_cfg(REG_WALL_0,     pack_wall(250, 150, 100, 100, MAT_GLASS));
        write_cfg(REG_WALL_0 + 1, pack_wall(0, 0, COORD_MAX, 0, MAT_COATED));
        write_cfg(REG_WALL_0 + 2, pack_wall(COORD_MAX, 0, COORD_MAX, COORD_MAX, MAT_CONCRETE));
        write_cfg(REG_WALL_0 + 3, pack_wall(0, COORD_MAX, COORD_MAX, COORD_MAX, MAT_WOOD));
        cfg_wr_en <= 1'b0;
        settings_seen++;
        send_pixel(300, 200, pick_gap());
        send_pixel(0, 0, pick_gap());
        send_pixel(COORD_MAX, 0, pick_gap());
        send_pixel(0, COORD_MAX, pick_gap());
        send_pixel(COORD_MAX, COORD_MAX, pick_gap());
        send_pixel(300, 0, pick_gap());
        send_pixel(0, 200, pick_gap());
        send_pixel(310, COORD_MAX, pick_gap());
        send_pixel(COORD_MAX, 210, pick_gap());
        send_pixel(301, 201, pick_gap());
        drain();

        // Empty and undefined materials covering the whole plane add nothing.
        write_cfg(REG_WALL_0,     pack_wall(0, 0, COORD_MAX, COORD_MAX, MAT_EMPTY));
        write_cfg(REG_WALL_0 + 1, pack_wall(0, 0, COORD_MAX, COORD_MAX, MAT_RSVD_5));
        write_cfg(REG_WALL_0 + 2, pack_wall(0, 0, COORD_MAX, COORD_MAX, MAT_RSVD_6));
        write_cfg(REG_WALL_0 + 3, pack_wall(0, 0, COORD_MAX, COORD_MAX, MAT_RSVD_7));
        cfg_wr_en <= 1'b0;
        settings_seen++;
        send_pixel(0, 0, pick_gap());
        send_pixel(COORD_MAX, COORD_MAX, pick_gap());
        send_pixel(512, 512, pick_gap());
        drain();

        // Heaviest loss: coated glass everywhere on the longest diagonal.
        write_cfg(REG_AP_X, '0);
        write_cfg(REG_AP_Y, '0);
        for (int k = 0; k < WALL_SLOTS; k++)
        begin
            write_cfg(REG_WALL_0 + k, pack_wall(0, 0, COORD_MAX, COORD_MAX, MAT_COATED));
        end
        cfg_wr_en <= 1'b0;
        settings_seen++;
        send_pixel(COORD_MAX, COORD_MAX, pick_gap());
        send_pixel(COORD_MAX, 0, pick_gap());
        send_pixel(0, 0, pick_gap());
        drain();

        // Same walls, access point at the far corner.
        write_cfg(REG_AP_X, WALL_W'(COORD_MAX));
        write_cfg(REG_AP_Y, WALL_W'(COORD_MAX));
        cfg_wr_en <= 1'b0;
        settings_seen++;
        send_pixel(0, 0, pick_gap());
        send_pixel(COORD_MAX, COORD_MAX, pick_gap());
        send_pixel(0, COORD_MAX, pick_gap());

        // Random phases: mostly short walks near the access point, some from anywhere.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            drain();
            randomize_config();
            quiet = (p % 3 == 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Halfway through, let the block run dry before the next transfer.
                if (i == PHASE_ITEMS / 2)
                    drain();
                r = $urandom_range(0, 99);
                if (r < 5)
                begin
                    px = int'(sb.ap_x);
                    py = int'(sb.ap_y);
                end
                else if (r < 70)
                begin
                    px = near_coord(int'(sb.ap_x), 48);
                    py = near_coord(int'(sb.ap_y), 48);
                end
                else
                begin
                    px = $urandom_range(0, COORD_MAX);
                    py = $urandom_range(0, COORD_MAX);
                end
                send_pixel(px, py, quiet ? 0 : pick_gap());
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.close_out();

        $display("Ran %0d pixel walks under %0d register settings; %0d results compared.",
                 sb.walks_noted, settings_seen, sb.results_checked);
        $display("Directed walks took in corners, straight and diagonal lines, %s",
                 "empty and undefined materials and the heaviest loss.");
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
